FILE: rtl/scalar_kalman_smoother_core_defines.svh
// ---------------------------------------------------------------------------
// scalar kalman smoother assertion macros
// shared concurrent assertion forms, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_SMOOTHER_CORE_DEFINES_SVH
`define SCALAR_KALMAN_SMOOTHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define SKALM_ASSERT_HOLD(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
// same-cycle implication
`define SKALM_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);
// next-cycle implication
`define SKALM_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define SKALM_ASSERT_HOLD(lbl, clk, rstn, cond, msg)
`define SKALM_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg)
`define SKALM_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

FILE: rtl/skalm_pkg.sv
// ---------------------------------------------------------------------------
// scalar kalman smoother package
// fixed widths, register indexes, reset values and shared types
// ---------------------------------------------------------------------------
package skalm_pkg;

	localparam int COV_WIDTH = 26;
	localparam int REG_WIDTH = 24;

	localparam logic [0:0] CFG_IDX_Q = 1'b0;
	localparam logic [0:0] CFG_IDX_R = 1'b1;

	localparam logic [REG_WIDTH-1:0] Q_RESET = 24'd5243;
	localparam logic [REG_WIDTH-1:0] R_RESET = 24'd49152;

	typedef struct packed {
		logic busy;
		logic done;
	} skalm_stat_t;

endpackage

FILE: rtl/skalm_div.sv
// ---------------------------------------------------------------------------
// skalm gain divider
// restoring divider, one quotient bit per cycle: floor(num*2^F / den)
// ---------------------------------------------------------------------------
module skalm_div import skalm_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [COV_WIDTH-1:0] num,
	input  logic [COV_WIDTH:0]   den,
	output logic [FRAC_BITS-1:0] quo,
	output skalm_stat_t          stat
);

	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	logic [COV_WIDTH:0]   rem_q;
	logic [COV_WIDTH:0]   den_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [COV_WIDTH+1:0] rem_dbl;
	logic [COV_WIDTH+1:0] den_ext;
	logic [COV_WIDTH+1:0] rem_nxt;
	logic                 fits;

	// remainder stays below den, so doubling needs one extra bit
	assign rem_dbl = {rem_q, 1'b0};
	assign den_ext = {1'b0, den_q};
	assign fits    = rem_dbl >= den_ext;
	assign rem_nxt = fits ? (rem_dbl - den_ext) : rem_dbl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_nxt[COV_WIDTH:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], fits};
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: rtl/skalm_mul.sv
// ---------------------------------------------------------------------------
// skalm serial multiplier
// gain bits lsb first, two shift-add products scaled down by 2^F with floor
// ---------------------------------------------------------------------------
module skalm_mul import skalm_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [FRAC_BITS-1:0]        gain,
	input  logic signed [DATA_WIDTH:0]  diff,
	input  logic [COV_WIDTH-1:0]        cov,
	output logic signed [DATA_WIDTH+1:0] eprod,
	output logic [COV_WIDTH-1:0]        cprod,
	output logic                        sticky,
	output skalm_stat_t                 stat
);

	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	logic [FRAC_BITS-1:0]         g_q;
	logic signed [DATA_WIDTH:0]   d_q;
	logic [COV_WIDTH-1:0]         p_q;
	logic signed [DATA_WIDTH+1:0] eacc_q;
	logic [COV_WIDTH-1:0]         cacc_q;
	logic                         sticky_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic                         done_q;

	logic signed [DATA_WIDTH+1:0] esum;
	logic [COV_WIDTH:0]           csum;

	assign esum = eacc_q + (g_q[0] ? (DATA_WIDTH+2)'(d_q) : '0);
	assign csum = {1'b0, cacc_q} + (g_q[0] ? {1'b0, p_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// floor shift each step: nested floors equal the floor of the whole product
	always_ff @(posedge clk) begin
		if (start) begin
			g_q      <= gain;
			d_q      <= diff;
			p_q      <= cov;
			eacc_q   <= '0;
			cacc_q   <= '0;
			sticky_q <= 1'b0;
		end else if (busy_q) begin
			g_q      <= g_q >> 1;
			eacc_q   <= {esum[DATA_WIDTH+1], esum[DATA_WIDTH+1:1]};
			cacc_q   <= csum[COV_WIDTH:1];
			sticky_q <= sticky_q | csum[0];
		end
	end

	assign eprod     = eacc_q;
	assign cprod     = cacc_q;
	assign sticky    = sticky_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: rtl/scalar_kalman_smoother_core.sv
// ---------------------------------------------------------------------------
// scalar kalman smoother core
// one-dimensional fixed point kalman filter over a stream of sensor samples
// ---------------------------------------------------------------------------
// A normal sample passes from acceptance through prediction, the
// bit-per-cycle gain divider, the bit-serial multiplier and a final step that
// updates the state and presents the result before the block can take the
// next one. A first or restart sample goes from acceptance straight to that
// final step. A result waits in the output register while the next sample is
// processed; the block only stalls at the end of a sample if that register
// has not yet been taken. Registers are to be written only while the block is
// idle; the block itself does not enforce this.
`include "scalar_kalman_smoother_core_defines.svh"

module scalar_kalman_smoother_core import skalm_pkg::*; #(
	parameter int  DATA_WIDTH = 32,
	parameter int  FRAC_BITS  = 16,
	localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [0:0]           cfg_index,
	input  logic [REG_WIDTH-1:0] cfg_data,
	// sample requests
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [TDATA_W-1:0]   s_tdata,  // measurement
	input  logic [0:0]           s_tuser,  // restart
	// results
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,  // smoothed
	output logic [0:0]           m_tuser   // first_sample
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PRED = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]            state_q;
	logic                  primed_q;
	logic                  init_q;
	logic                  go_q;
	logic [REG_WIDTH-1:0]  q_reg_q;
	logic [REG_WIDTH-1:0]  r_reg_q;
	logic [DATA_WIDTH-1:0] z_q;
	logic [DATA_WIDTH-1:0] est_q;
	logic [COV_WIDTH-1:0]  cov_q;
	logic [COV_WIDTH-1:0]  p_q;
	logic signed [DATA_WIDTH:0] diff_q;
	logic                  m_tvalid_q;
	logic [DATA_WIDTH-1:0] m_data_q;
	logic                  m_first_q;

	logic                  s_take;
	logic                  out_free;
	logic [COV_WIDTH:0]    p_sum;
	logic [COV_WIDTH-1:0]  p_sat;
	logic [REG_WIDTH-1:0]  r_eff;
	logic [COV_WIDTH:0]    den;
	logic                  div_start;
	logic                  mul_start;
	logic [FRAC_BITS-1:0]  gain;
	skalm_stat_t           div_stat;
	skalm_stat_t           mul_stat;
	logic signed [DATA_WIDTH+1:0] eprod;
	logic [COV_WIDTH-1:0]  cprod;
	logic                  sticky;
	logic signed [DATA_WIDTH+1:0] est_sum;
	logic                  est_ovf;
	logic [DATA_WIDTH-1:0] est_next;
	logic [COV_WIDTH-1:0]  cov_next;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_take    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;

	// prediction: covariance plus process noise, clamped
	assign p_sum = {1'b0, cov_q} + (COV_WIDTH+1)'(q_reg_q);
	assign p_sat = p_sum[COV_WIDTH] ? '1 : p_sum[COV_WIDTH-1:0];

	// zero noise is taken as one lsb in the divisor
	assign r_eff = (r_reg_q == '0) ? REG_WIDTH'(1) : r_reg_q;
	assign den   = {1'b0, p_q} + (COV_WIDTH+1)'(r_eff);

	assign div_start = go_q;
	assign mul_start = (state_q == ST_DIV) && div_stat.done;

	skalm_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (p_q),
		.den    (den),
		.quo    (gain),
		.stat   (div_stat)
	);

	skalm_mul #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.gain   (gain),
		.diff   (diff_q),
		.cov    (p_q),
		.eprod  (eprod),
		.cprod  (cprod),
		.sticky (sticky),
		.stat   (mul_stat)
	);

	// estimate update with signed clamp
	assign est_sum = (DATA_WIDTH+2)'($signed(est_q)) + eprod;
	assign est_ovf = (est_sum[DATA_WIDTH+1:DATA_WIDTH-1] != 3'b000) &&
		(est_sum[DATA_WIDTH+1:DATA_WIDTH-1] != 3'b111);

	always_comb begin
		if (est_ovf) begin
			est_next = {est_sum[DATA_WIDTH+1], {(DATA_WIDTH-1){~est_sum[DATA_WIDTH+1]}}};
		end else begin
			est_next = est_sum[DATA_WIDTH-1:0];
		end
	end

	// (1 - gain) * p, floor, is p minus the ceiling of gain * p
	assign cov_next = p_q - cprod - COV_WIDTH'(sticky);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_reg_q <= Q_RESET;
			r_reg_q <= R_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_IDX_Q: q_reg_q <= cfg_data;
				CFG_IDX_R: r_reg_q <= cfg_data;
				default:   q_reg_q <= q_reg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			primed_q   <= 1'b0;
			init_q     <= 1'b0;
			go_q       <= 1'b0;
			est_q      <= '0;
			cov_q      <= COV_WIDTH'(1) << FRAC_BITS;
			m_tvalid_q <= 1'b0;
		end else begin
			go_q <= (state_q == ST_PRED);
			if ((state_q == ST_FIN) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_take) begin
						init_q  <= s_tuser[0] || !primed_q;
						state_q <= (s_tuser[0] || !primed_q) ? ST_FIN : ST_PRED;
					end
				end
				ST_PRED: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_stat.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						primed_q <= 1'b1;
						state_q  <= ST_IDLE;
						if (init_q) begin
							est_q <= z_q;
							cov_q <= COV_WIDTH'(r_reg_q);
						end else begin
							est_q <= est_next;
							cov_q <= cov_next;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_take) begin
			z_q <= s_tdata[DATA_WIDTH-1:0];
		end
		if (state_q == ST_PRED) begin
			p_q    <= p_sat;
			diff_q <= $signed({z_q[DATA_WIDTH-1], z_q}) - $signed({est_q[DATA_WIDTH-1], est_q});
		end
		if ((state_q == ST_FIN) && out_free) begin
			m_data_q  <= init_q ? z_q : est_next;
			m_first_q <= init_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_W'(m_data_q);
	assign m_tuser  = m_first_q;

	`SKALM_ASSERT_IMPL(a_div_in_div, clk, arst_n, div_stat.busy, state_q == ST_DIV, "divider busy outside divide")
	`SKALM_ASSERT_NEXT(a_div_to_mul, clk, arst_n, div_stat.done, state_q == ST_MUL, "gain ready but multiply not started")
	`SKALM_ASSERT_IMPL(a_mul_in_mul, clk, arst_n, mul_stat.busy, state_q == ST_MUL, "multiplier busy outside multiply")
	`SKALM_ASSERT_NEXT(a_restart_init, clk, arst_n, s_take && s_tuser[0], (state_q == ST_FIN) && init_q, "restart request did not initialize")

endmodule
